[sv/zpsf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Zero-phase smoothing filter package
// Widths, constants, request types and helper codes shared by the filter.
// ----------------------------------------------------------------------------
package zpsf_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int LEVEL_W    = 15;
    localparam int PASS_W     = 3;
    localparam int MAX_PASSES = 4;
    localparam int LEFT_W     = $clog2(MAX_PASSES + 1);

    localparam logic [LEVEL_W-1:0] LEVEL_TOP = 15'h7FFF;
    localparam logic [PASS_W-1:0]  PASS_RST  = 3'd1;

    // Weighted sum width: 6 * 32767 plus rounding fits in 18 bits
    localparam int SUM_W   = 18;
    localparam int MAGIC_W = 19;
    localparam int PROD_W  = SUM_W + MAGIC_W;

    // Reciprocals for exact floor division of an 18-bit sum
    localparam logic [MAGIC_W-1:0] MAGIC_3 = 19'd349526;
    localparam logic [MAGIC_W-1:0] MAGIC_5 = 19'd419431;
    localparam logic [MAGIC_W-1:0] MAGIC_6 = 19'd349526;
    localparam int SHIFT_3 = 20;
    localparam int SHIFT_5 = 21;
    localparam int SHIFT_6 = 21;

    // Front-to-back queue and output queue
    localparam int Q_DEPTH  = 4;
    localparam int Q_AW     = $clog2(Q_DEPTH);
    localparam int OQ_DEPTH = 2;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);

    typedef enum logic [1:0] {
        DIV_NONE,
        DIV_3,
        DIV_5,
        DIV_6
    } t_div;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_in;
        logic                       last_in;
    } t_in;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       last_out;
        logic [LEVEL_W-1:0]         max_level;
        logic [LEVEL_W-1:0]         min_level;
    } t_out;

    // Request travelling through the cascade: sample, end flag, passes left
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
        logic [LEFT_W-1:0]          left;
    } t_tok;

    // Operands of one smoothing evaluation
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] c;
        logic signed [SAMPLE_W-1:0] n1;
        logic signed [SAMPLE_W-1:0] n2;
        logic                       h1;
        logic                       h2;
        logic                       byp;
        logic                       last;
        logic [LEFT_W-1:0]          left;
    } t_opnd;

endpackage

[sv/zpsf_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Zero-phase smoothing filter front end
// Holds the pass count register, latches it at the first sample of each
// stream and tags every accepted request with the number of passes to run.
// ----------------------------------------------------------------------------
module zpsf_front import zpsf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [PASS_W-1:0] i_cfg_wdata,
    input  logic              i_push,
    output logic              o_full,
    input  t_in               i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output t_tok              o_tok
);

    logic [PASS_W-1:0] r_pass_count;
    logic              r_in_stream;
    logic [LEFT_W-1:0] r_passes;
    logic [LEFT_W-1:0] n_passes;
    logic              accept;

    assign o_full  = !i_ready;
    assign o_valid = i_push;
    assign accept  = i_push && i_ready;

    // Clamp the configured count at stream start, else keep the latched one
    always_comb begin
        n_passes = r_passes;
        if (!r_in_stream) begin
            if (r_pass_count == '0) begin
                n_passes = LEFT_W'(1);
            end else if (int'(r_pass_count) > MAX_PASSES) begin
                n_passes = LEFT_W'(MAX_PASSES);
            end else begin
                n_passes = LEFT_W'(r_pass_count);
            end
        end
    end

    always_comb begin
        o_tok.sample = i_data.sample_in;
        o_tok.last   = i_data.last_in;
        o_tok.left   = n_passes;
    end

    // Hold configuration and stream state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pass_count <= PASS_RST;
            r_in_stream  <= 1'b0;
            r_passes     <= LEFT_W'(1);
        end else begin
            if (i_cfg_we) begin
                r_pass_count <= i_cfg_wdata;
            end
            if (accept) begin
                r_passes    <= n_passes;
                r_in_stream <= !i_data.last_in;
            end
        end
    end

endmodule

[sv/zpsf_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Zero-phase smoothing filter request queue
// Short queue between the front end and the filter cascade.
// ----------------------------------------------------------------------------
module zpsf_fifo import zpsf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_tok i_tok,
    output logic o_valid,
    input  logic i_ready,
    output t_tok o_tok
);

    t_tok            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp;
    logic [Q_AW-1:0] r_rp;
    logic [Q_AW:0]   r_cnt;
    logic            wr;
    logic            rd;

    assign o_ready = (r_cnt != (Q_AW+1)'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_tok   = r_mem[r_rp];
    assign wr      = i_valid && o_ready;
    assign rd      = o_valid && i_ready;

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= r_wp + Q_AW'(1);
            end
            if (rd) begin
                r_rp <= r_rp + Q_AW'(1);
            end
            if (wr && !rd) begin
                r_cnt <= r_cnt + (Q_AW+1)'(1);
            end else if (rd && !wr) begin
                r_cnt <= r_cnt - (Q_AW+1)'(1);
            end
        end
    end

    // Store incoming request
    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_tok;
        end
    end

endmodule

[sv/zpsf_smooth.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Zero-phase smoothing filter arithmetic unit
// Two-stage pipeline: weighted, rounded sum with divisor choice, then
// division by 3, 5 or 6 through a reciprocal multiply.
// ----------------------------------------------------------------------------
module zpsf_smooth import zpsf_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_opnd i_opnd,
    output logic  o_valid,
    input  logic  i_ready,
    output t_tok  o_tok
);

    logic                       r_v1;
    logic [SUM_W-1:0]           r_sum;
    t_div                       r_div;
    logic signed [SAMPLE_W-1:0] r_c;
    logic                       r_last;
    logic [LEFT_W-1:0]          r_left;
    logic                       r_v2;
    t_tok                       r_tok;

    logic [SUM_W-1:0]           n_sum;
    t_div                       n_div;
    logic [PROD_W-1:0]          prod;
    logic signed [SAMPLE_W-1:0] n_res;
    logic                       s1_rdy;
    logic                       s2_rdy;

    assign s2_rdy  = !r_v2 || i_ready;
    assign s1_rdy  = !r_v1 || s2_rdy;
    assign o_ready = s1_rdy;
    assign o_valid = r_v2;
    assign o_tok   = r_tok;

    // Build the weighted sum; drop neighbours that are absent or markers
    always_comb begin
        n_sum = SUM_W'({i_opnd.c[SAMPLE_W-2:0], 1'b0}) + SUM_W'(i_opnd.c[SAMPLE_W-2:0]);
        n_div = DIV_3;
        if (i_opnd.c[SAMPLE_W-1] || i_opnd.byp) begin
            n_div = DIV_NONE;
        end else if (i_opnd.h1 && !i_opnd.n1[SAMPLE_W-1]) begin
            n_sum = n_sum + SUM_W'({i_opnd.n1[SAMPLE_W-2:0], 1'b0});
            n_div = DIV_5;
            if (i_opnd.h2 && !i_opnd.n2[SAMPLE_W-1]) begin
                n_sum = n_sum + SUM_W'(i_opnd.n2[SAMPLE_W-2:0]);
                n_div = DIV_6;
            end
        end
        // Add half the divisor for rounding
        case (n_div)
            DIV_3:   n_sum = n_sum + SUM_W'(1);
            DIV_5:   n_sum = n_sum + SUM_W'(2);
            DIV_6:   n_sum = n_sum + SUM_W'(3);
            default: n_sum = n_sum;
        endcase
    end

    // Divide by reciprocal multiply; markers and bypassed samples pass as is
    always_comb begin
        prod  = '0;
        n_res = r_c;
        case (r_div)
            DIV_3: begin
                prod  = PROD_W'(r_sum) * PROD_W'(MAGIC_3);
                n_res = SAMPLE_W'(prod[SHIFT_3 +: LEVEL_W]);
            end
            DIV_5: begin
                prod  = PROD_W'(r_sum) * PROD_W'(MAGIC_5);
                n_res = SAMPLE_W'(prod[SHIFT_5 +: LEVEL_W]);
            end
            DIV_6: begin
                prod  = PROD_W'(r_sum) * PROD_W'(MAGIC_6);
                n_res = SAMPLE_W'(prod[SHIFT_6 +: LEVEL_W]);
            end
            default: begin
                prod  = '0;
                n_res = r_c;
            end
        endcase
    end

    // Advance stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (s1_rdy) begin
                r_v1 <= i_valid;
            end
            if (s2_rdy) begin
                r_v2 <= r_v1;
            end
        end
    end

    // Load stage payloads
    always_ff @(posedge i_clk) begin
        if (s1_rdy && i_valid) begin
            r_sum  <= n_sum;
            r_div  <= n_div;
            r_c    <= i_opnd.c;
            r_last <= i_opnd.last;
            r_left <= i_opnd.left;
        end
        if (s2_rdy && r_v1) begin
            r_tok.sample <= n_res;
            r_tok.last   <= r_last;
            r_tok.left   <= r_left;
        end
    end

endmodule

[sv/zpsf_pass.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Zero-phase smoothing filter pass
// One double pass: a causal 3-2-1 filter over the incoming samples, then an
// anti-causal 3-2-1 filter with two samples of lookahead. The request that
// ends a stream flushes the lookahead. Requests with no passes left bypass.
// ----------------------------------------------------------------------------
module zpsf_pass import zpsf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_tok i_tok,
    output logic o_valid,
    input  logic i_ready,
    output t_tok o_tok
);

    // Causal half
    logic signed [SAMPLE_W-1:0] r_p0;
    logic signed [SAMPLE_W-1:0] r_p1;
    logic [1:0]                 r_pf;
    t_opnd                      c_opnd;
    logic                       c_rdy;
    logic                       c_take;

    // Link between halves
    logic                       m_valid;
    logic                       m_ready;
    t_tok                       m_tok;

    // Anti-causal half
    logic signed [SAMPLE_W-1:0] r_w0;
    logic signed [SAMPLE_W-1:0] r_w1;
    logic [1:0]                 r_cnt;
    logic                       r_fl;
    logic signed [SAMPLE_W-1:0] r_f0;
    logic signed [SAMPLE_W-1:0] r_f1;
    logic signed [SAMPLE_W-1:0] r_f2;
    logic [1:0]                 r_fm;
    logic [1:0]                 r_fi;
    logic [LEFT_W-1:0]          r_fleft;

    logic signed [SAMPLE_W-1:0] n_w0;
    logic signed [SAMPLE_W-1:0] n_w1;
    logic [1:0]                 n_cnt;
    logic                       n_fl;
    logic signed [SAMPLE_W-1:0] n_f0;
    logic signed [SAMPLE_W-1:0] n_f1;
    logic signed [SAMPLE_W-1:0] n_f2;
    logic [1:0]                 n_fm;
    logic [1:0]                 n_fi;
    logic [LEFT_W-1:0]          n_fleft;

    t_opnd                      a_opnd;
    logic                       a_valid;
    logic                       a_rdy;

    // Causal operands: current sample and the two before it
    always_comb begin
        c_opnd      = '0;
        c_opnd.c    = i_tok.sample;
        c_opnd.n1   = r_p0;
        c_opnd.n2   = r_p1;
        c_opnd.h1   = (r_pf != 2'd0);
        c_opnd.h2   = (r_pf == 2'd2);
        c_opnd.byp  = (i_tok.left == '0);
        c_opnd.last = i_tok.last;
        c_opnd.left = i_tok.left;
    end

    assign o_ready = c_rdy;
    assign c_take  = i_valid && c_rdy && (i_tok.left != '0);

    zpsf_smooth u_causal (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (c_rdy),
        .i_opnd  (c_opnd),
        .o_valid (m_valid),
        .i_ready (m_ready),
        .o_tok   (m_tok)
    );

    // Hold the causal history; drop it at the end of a stream
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pf <= 2'd0;
        end else if (c_take) begin
            if (i_tok.last) begin
                r_pf <= 2'd0;
            end else if (r_pf != 2'd2) begin
                r_pf <= r_pf + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_take) begin
            r_p0 <= i_tok.sample;
            r_p1 <= r_p0;
        end
    end

    // Anti-causal control: fill the lookahead, issue, or flush at stream end
    always_comb begin
        n_w0    = r_w0;
        n_w1    = r_w1;
        n_cnt   = r_cnt;
        n_fl    = r_fl;
        n_f0    = r_f0;
        n_f1    = r_f1;
        n_f2    = r_f2;
        n_fm    = r_fm;
        n_fi    = r_fi;
        n_fleft = r_fleft;
        a_valid = 1'b0;
        a_opnd  = '0;
        m_ready = 1'b0;
        if (r_fl) begin
            // Flush: one result a cycle while the anti-causal unit is ready, the last one carries the end flag
            a_valid = 1'b1;
            case (r_fi)
                2'd0:    a_opnd.c = r_f0;
                2'd1:    a_opnd.c = r_f1;
                default: a_opnd.c = r_f2;
            endcase
            a_opnd.n1   = (r_fi == 2'd0) ? r_f1 : r_f2;
            a_opnd.n2   = r_f2;
            a_opnd.h1   = ({1'b0, r_fi} + 3'd1) < {1'b0, r_fm};
            a_opnd.h2   = ({1'b0, r_fi} + 3'd2) < {1'b0, r_fm};
            a_opnd.last = ({1'b0, r_fi} + 3'd1) == {1'b0, r_fm};
            a_opnd.left = r_fleft - LEFT_W'(1);
            if (a_rdy) begin
                if (a_opnd.last) begin
                    n_fl = 1'b0;
                end else begin
                    n_fi = r_fi + 2'd1;
                end
            end
        end else if (m_valid) begin
            if (m_tok.left == '0) begin
                // Pass through untouched
                a_valid     = 1'b1;
                a_opnd.c    = m_tok.sample;
                a_opnd.byp  = 1'b1;
                a_opnd.last = m_tok.last;
                m_ready     = a_rdy;
            end else if (m_tok.last) begin
                // Capture the tail of the stream for the flush
                m_ready = 1'b1;
                n_fl    = 1'b1;
                n_fi    = 2'd0;
                n_fm    = r_cnt + 2'd1;
                n_fleft = m_tok.left;
                n_cnt   = 2'd0;
                case (r_cnt)
                    2'd0: begin
                        n_f0 = m_tok.sample;
                    end
                    2'd1: begin
                        n_f0 = r_w0;
                        n_f1 = m_tok.sample;
                    end
                    default: begin
                        n_f0 = r_w0;
                        n_f1 = r_w1;
                        n_f2 = m_tok.sample;
                    end
                endcase
            end else if (r_cnt == 2'd2) begin
                // Lookahead full: issue the oldest and shift
                a_valid     = 1'b1;
                a_opnd.c    = r_w0;
                a_opnd.n1   = r_w1;
                a_opnd.n2   = m_tok.sample;
                a_opnd.h1   = 1'b1;
                a_opnd.h2   = 1'b1;
                a_opnd.left = m_tok.left - LEFT_W'(1);
                m_ready     = a_rdy;
                if (a_rdy) begin
                    n_w0 = r_w1;
                    n_w1 = m_tok.sample;
                end
            end else begin
                // Still filling the lookahead
                m_ready = 1'b1;
                n_cnt   = r_cnt + 2'd1;
                if (r_cnt == 2'd0) begin
                    n_w0 = m_tok.sample;
                end else begin
                    n_w1 = m_tok.sample;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_fl  <= 1'b0;
            r_fi  <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            r_fl  <= n_fl;
            r_fi  <= n_fi;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w0    <= n_w0;
        r_w1    <= n_w1;
        r_f0    <= n_f0;
        r_f1    <= n_f1;
        r_f2    <= n_f2;
        r_fm    <= n_fm;
        r_fleft <= n_fleft;
    end

    zpsf_smooth u_anti (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (a_valid),
        .o_ready (a_rdy),
        .i_opnd  (a_opnd),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_tok   (o_tok)
    );

endmodule

[sv/zpsf_levels.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Zero-phase smoothing filter level tracker
// Keeps running maximum and minimum of the non-negative results of a stream
// and queues finished results for the output side.
// ----------------------------------------------------------------------------
module zpsf_levels import zpsf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_tok i_tok,
    output logic o_empty,
    input  logic i_pop,
    output t_out o_data
);

    t_out               r_mem [OQ_DEPTH];
    logic [OQ_AW-1:0]   r_wp;
    logic [OQ_AW-1:0]   r_rp;
    logic [OQ_AW:0]     r_cnt;
    logic [LEVEL_W-1:0] r_max;
    logic [LEVEL_W-1:0] r_min;
    logic [LEVEL_W-1:0] n_max;
    logic [LEVEL_W-1:0] n_min;
    t_out               entry;
    logic               wr;
    logic               rd;

    assign o_ready = (r_cnt != (OQ_AW+1)'(OQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign wr      = i_valid && o_ready;
    assign rd      = i_pop && !o_empty;

    // Fold this result into the running levels; markers do not count
    always_comb begin
        n_max = r_max;
        n_min = r_min;
        if (!i_tok.sample[SAMPLE_W-1]) begin
            if (i_tok.sample[LEVEL_W-1:0] > r_max) begin
                n_max = i_tok.sample[LEVEL_W-1:0];
            end
            if (i_tok.sample[LEVEL_W-1:0] < r_min) begin
                n_min = i_tok.sample[LEVEL_W-1:0];
            end
        end
        entry.sample_out = i_tok.sample;
        entry.last_out   = i_tok.last;
        entry.max_level  = n_max;
        entry.min_level  = n_min;
    end

    // Update levels, restart them after the end of a stream; advance queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= '0;
            r_min <= LEVEL_TOP;
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_max <= i_tok.last ? '0 : n_max;
                r_min <= i_tok.last ? LEVEL_TOP : n_min;
                r_wp  <= r_wp + OQ_AW'(1);
            end
            if (rd) begin
                r_rp <= r_rp + OQ_AW'(1);
            end
            if (wr && !rd) begin
                r_cnt <= r_cnt + (OQ_AW+1)'(1);
            end else if (rd && !wr) begin
                r_cnt <= r_cnt - (OQ_AW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= entry;
        end
    end

endmodule

[sv/zero_phase_smoothing_filter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Zero-phase smoothing filter
// Each pass applies a causal and an anti-causal 3-2-1 smoothing filter; up to
// MAX_PASSES passes run as a cascade, with running output levels.
// ----------------------------------------------------------------------------
// The block takes one sample per clock and gives one result per clock in
// steady state while results are popped. The pass count is taken from its
// register at the first sample of each stream. Every active pass holds back
// two samples, so a stream's results trail its samples by two per active
// pass. Each of the MAX_PASSES passes carries a request through the stage
// registers of both filter halves' arithmetic units, and an inactive pass
// still carries the request through both units. The sample flagged last
// flushes each pass in turn: each pass first captures its lookahead without
// issuing a result and then issues the held results at one a cycle while its
// anti-causal unit is ready; that half takes nothing from the causal half
// until its flush is done. Results wait in a two-entry output queue.
// ----------------------------------------------------------------------------
module zero_phase_smoothing_filter import zpsf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [PASS_W-1:0] i_cfg_wdata,
    input  logic              push,
    output logic              full,
    input  t_in               i_data,
    output logic              empty,
    input  logic              pop,
    output t_out              o_data
);

    logic f_valid;
    logic f_ready;
    t_tok f_tok;
    logic s_valid [MAX_PASSES+1];
    logic s_ready [MAX_PASSES+1];
    t_tok s_tok   [MAX_PASSES+1];

    // Accept and tag requests
    zpsf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_push      (push),
        .o_full      (full),
        .i_data      (i_data),
        .o_valid     (f_valid),
        .i_ready     (f_ready),
        .o_tok       (f_tok)
    );

    // Decouple front end from the cascade
    zpsf_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_tok   (f_tok),
        .o_valid (s_valid[0]),
        .i_ready (s_ready[0]),
        .o_tok   (s_tok[0])
    );

    // Cascade of passes
    for (genvar k = 0; k < MAX_PASSES; k++) begin : g_pass
        zpsf_pass u_pass (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (s_valid[k]),
            .o_ready (s_ready[k]),
            .i_tok   (s_tok[k]),
            .o_valid (s_valid[k+1]),
            .i_ready (s_ready[k+1]),
            .o_tok   (s_tok[k+1])
        );
    end

    // Track levels and queue results
    zpsf_levels u_levels (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_valid[MAX_PASSES]),
        .o_ready (s_ready[MAX_PASSES]),
        .i_tok   (s_tok[MAX_PASSES]),
        .o_empty (empty),
        .i_pop   (pop),
        .o_data  (o_data)
    );

endmodule
